FILE: hw/rtl/eusb_pkg.sv
// Shared types and constants for the escape and UTF-8 boundary scanner.
package eusb_pkg;

   localparam int LENGTH_BITS = 24;
   localparam int OUT_LEN_BITS = 24;

   typedef logic [LENGTH_BITS-1:0] pos_type;

   typedef enum logic [2:0] {
      MODE_GROUND  = 3'd0,
      MODE_ESC     = 3'd1,
      MODE_CSI     = 3'd2,
      MODE_STR     = 3'd3,
      MODE_STR_ESC = 3'd4,
      MODE_UTF8    = 3'd5
   } mode_type;

   localparam logic [7:0] CHR_BEL    = 8'h07;
   localparam logic [7:0] CHR_ESC    = 8'h1B;
   localparam logic [7:0] CHR_CSI    = 8'h5B;
   localparam logic [7:0] CHR_BSLASH = 8'h5C;
   localparam logic [7:0] CHR_OSC    = 8'h5D;
   localparam logic [7:0] CHR_DCS    = 8'h50;
   localparam logic [7:0] CHR_PM     = 8'h5E;
   localparam logic [7:0] CHR_APC    = 8'h5F;
   localparam logic [7:0] CHR_SOS    = 8'h58;
   localparam logic [7:0] FINAL_LO   = 8'h40;
   localparam logic [7:0] FINAL_HI   = 8'h7E;

endpackage

FILE: hw/rtl/escape_utf8_safe_break_scanner_unit.sv
// Top level: escape/CSI/string/UTF-8 unit boundary scanner with safe prefix length.
//
//  channel | ports                                   | direction
//  req     | req_valid req_stall req_byte_in         | in  (stall out)
//          | req_start_buffer                        |
//  rsp     | rsp_valid rsp_stall rsp_unit_end        | out (stall in)
//          | rsp_safe_length rsp_inside_unit         |
//
// One item per cycle unless req_stall; results show in the cycle after acceptance.
// Parse state and counters update in the accept cycle, feeding the next byte.
// Reset empties the result register and returns the parser to ground state.
// req_stall is high only while a result is held and rsp_stall is high.
module escape_utf8_safe_break_scanner_unit
   import eusb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_in,
   input  logic        req_start_buffer,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_unit_end,
   output logic [23:0] rsp_safe_length,
   output logic        rsp_inside_unit
);

   localparam pos_type POS_MAX = {LENGTH_BITS{1'b1}};

   mode_type mode_ff, mode_in;
   logic [1:0] left_ff, left_in;
   pos_type pos_ff, pos_in;
   pos_type last_ff, last_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_unit_end_ff, rsp_unit_end_in;
   logic [OUT_LEN_BITS-1:0] rsp_len_ff, rsp_len_in;
   logic rsp_inside_ff, rsp_inside_in;

   logic accept;
   logic ended;
   mode_type mode_cur;
   logic [1:0] left_cur;
   pos_type pos_cur;
   pos_type last_cur;
   logic [47:0] last_wide;
   logic [7:0] b;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign b         = req_byte_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_GROUND;
         left_ff      <= 2'd0;
         pos_ff       <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         left_ff      <= left_in;
         pos_ff       <= pos_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_unit_end_ff <= rsp_unit_end_in;
         rsp_len_ff      <= rsp_len_in;
         rsp_inside_ff   <= rsp_inside_in;
      end
   end

   always_comb begin
      mode_cur = req_start_buffer ? MODE_GROUND : mode_ff;
      left_cur = req_start_buffer ? 2'd0 : left_ff;
      pos_cur  = req_start_buffer ? '0 : pos_ff;
      last_cur = req_start_buffer ? '0 : last_ff;

      mode_in  = mode_cur;
      left_in  = left_cur;
      ended    = 1'b0;

      case (mode_cur)
         MODE_ESC: begin
            if (b == CHR_CSI) begin
               mode_in = MODE_CSI;
            end else if (b inside {CHR_OSC, CHR_DCS, CHR_PM, CHR_APC, CHR_SOS}) begin
               mode_in = MODE_STR;
            end else begin
               mode_in = MODE_GROUND;
               ended   = 1'b1;
            end
         end
         MODE_CSI: begin
            if (b >= FINAL_LO && b <= FINAL_HI) begin
               mode_in = MODE_GROUND;
               ended   = 1'b1;
            end
         end
         MODE_STR, MODE_STR_ESC: begin
            if (mode_cur == MODE_STR_ESC && b == CHR_BSLASH) begin
               mode_in = MODE_GROUND;
               ended   = 1'b1;
            end else if (b == CHR_BEL) begin
               mode_in = MODE_GROUND;
               ended   = 1'b1;
            end else if (b == CHR_ESC) begin
               mode_in = MODE_STR_ESC;
            end else begin
               mode_in = MODE_STR;
            end
         end
         MODE_UTF8: begin
            left_in = left_cur - 2'd1;
            if (left_in == 2'd0) begin
               mode_in = MODE_GROUND;
               ended   = 1'b1;
            end
         end
         default: begin
            mode_in = MODE_GROUND;
            if (b == CHR_ESC) begin
               mode_in = MODE_ESC;
            end else if (!b[7]) begin
               ended = 1'b1;
            end else if (b[7:5] == 3'b110) begin
               left_in = 2'd1;
               mode_in = MODE_UTF8;
            end else if (b[7:4] == 4'b1110) begin
               left_in = 2'd2;
               mode_in = MODE_UTF8;
            end else if (b[7:3] == 5'b11110) begin
               left_in = 2'd3;
               mode_in = MODE_UTF8;
            end else begin
               ended = 1'b1;
            end
         end
      endcase

      pos_in  = (pos_cur != POS_MAX) ? pos_cur + pos_type'(1) : pos_cur;
      last_in = ended ? pos_in : last_cur;

      last_wide = 48'(last_in);
      if (last_wide[47:OUT_LEN_BITS] != '0) begin
         rsp_len_in = {OUT_LEN_BITS{1'b1}};
      end else begin
         rsp_len_in = last_wide[OUT_LEN_BITS-1:0];
      end
      rsp_unit_end_in = ended;
      rsp_inside_in   = (mode_in != MODE_GROUND);

      if (!accept) begin
         mode_in = mode_ff;
         left_in = left_ff;
         pos_in  = pos_ff;
         last_in = last_ff;
      end

      rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_unit_end    = rsp_unit_end_ff;
   assign rsp_safe_length = rsp_len_ff;
   assign rsp_inside_unit = rsp_inside_ff;

   a_end_not_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_unit_end |-> !rsp_inside_unit)
      else $error("unit end reported while a unit is still open");

   a_utf8_count: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_UTF8 |-> left_ff != 2'd0)
      else $error("codepoint pending with no bytes left");

   a_last_le_pos: assert property (@(posedge clock) disable iff (reset)
      last_ff <= pos_ff)
      else $error("safe position beyond byte position");

   a_start_pos: assert property (@(posedge clock) disable iff (reset)
      accept && req_start_buffer |=> pos_ff == pos_type'(1))
      else $error("buffer start did not restart the byte count");

endmodule
